/* hw/rtl/stc_pkg.sv */
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and codes of the scope trigger and capture controller.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int MAX_BUFFERS     = 8;
    localparam int MAX_BUFFER_SIZE = 4096;

    localparam int IDX_W   = 4;
    localparam int ACC_W   = 5;
    localparam int SIZE_W  = 13;
    localparam int CNT_W   = 17;
    localparam int TMO_W   = 16;
    localparam int PRE_W   = 3;

    localparam logic [2:0] MODE_START   = 3'd0;
    localparam logic [2:0] MODE_ENABLE  = 3'd1;
    localparam logic [2:0] MODE_DISABLE = 3'd2;
    localparam logic [2:0] MODE_HIT     = 3'd3;
    localparam logic [2:0] MODE_BUF_END = 3'd4;
    localparam logic [2:0] MODE_FULL    = 3'd5;
    localparam logic [2:0] MODE_GET_RD  = 3'd6;
    localparam logic [2:0] MODE_ADV_RD  = 3'd7;

    localparam logic [2:0] ST_DISABLED  = 3'd0;
    localparam logic [2:0] ST_ENABLED   = 3'd1;
    localparam logic [2:0] ST_ARMED     = 3'd2;
    localparam logic [2:0] ST_CAPTURING = 3'd3;
    localparam logic [2:0] ST_DONE      = 3'd4;
    localparam logic [2:0] ST_READING   = 3'd5;

    localparam logic [2:0] REG_COUNT    = 3'd0;
    localparam logic [2:0] REG_SIZE     = 3'd1;
    localparam logic [2:0] REG_PRE      = 3'd2;
    localparam logic [2:0] REG_TIMEOUT  = 3'd3;
    localparam logic [2:0] REG_EDGE     = 3'd4;

    localparam logic [1:0] CMP_OFF      = 2'd0;
    localparam logic [1:0] CMP_BELOW    = 2'd1;
    localparam logic [1:0] CMP_ABOVE    = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [IDX_W-1:0]  count;
        logic [SIZE_W-1:0] size;
        logic [PRE_W-1:0]  pre;
        logic [TMO_W-1:0]  timeout;
        logic              rising;
    } cfg_t;

    typedef struct packed {
        logic [ACC_W-1:0] sum;
        logic             ge;
        logic [ACC_W-1:0] diff;
    } wrap_res_t;

endpackage

/* hw/rtl/stc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// stc_cfg_regs
// Configuration registers with the clamped ring count and buffer size.
// ----------------------------------------------------------------------------
module stc_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [2:0]    wr_index,
    input  logic [15:0]   wr_data,
    output stc_pkg::cfg_t cfg
);

    logic [stc_pkg::IDX_W-1:0]  count_reg;
    logic [stc_pkg::SIZE_W-1:0] size_reg;
    logic [stc_pkg::PRE_W-1:0]  pre_reg;
    logic [stc_pkg::TMO_W-1:0]  timeout_reg;
    logic                       rising_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= 4'd8;
            size_reg    <= 13'd4096;
            pre_reg     <= 3'd1;
            timeout_reg <= 16'd0;
            rising_reg  <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                stc_pkg::REG_COUNT:   count_reg   <= wr_data[3:0];
                stc_pkg::REG_SIZE:    size_reg    <= wr_data[12:0];
                stc_pkg::REG_PRE:     pre_reg     <= wr_data[2:0];
                stc_pkg::REG_TIMEOUT: timeout_reg <= wr_data[15:0];
                stc_pkg::REG_EDGE:    rising_reg  <= wr_data[0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        if (count_reg < 4'd2)
            cfg.count = 4'd2;
        else if (32'(count_reg) > stc_pkg::MAX_BUFFERS)
            cfg.count = 4'(stc_pkg::MAX_BUFFERS);
        else
            cfg.count = count_reg;

        if (size_reg < 13'd1)
            cfg.size = 13'd1;
        else if (32'(size_reg) > stc_pkg::MAX_BUFFER_SIZE)
            cfg.size = 13'(stc_pkg::MAX_BUFFER_SIZE);
        else
            cfg.size = size_reg;

        cfg.pre     = pre_reg;
        cfg.timeout = timeout_reg;
        cfg.rising  = rising_reg;
    end

endmodule

/* hw/rtl/stc_wrap_unit.sv */
// ----------------------------------------------------------------------------
// stc_wrap_unit
// Shared ring index unit: add, compare against the ring count, subtract.
// ----------------------------------------------------------------------------
module stc_wrap_unit (
    input  logic [stc_pkg::ACC_W-1:0] a,
    input  logic [1:0]                b,
    input  logic [stc_pkg::IDX_W-1:0] n,
    output stc_pkg::wrap_res_t        res
);

    logic [stc_pkg::ACC_W-1:0] n_ext;

    assign n_ext    = {1'b0, n};
    assign res.sum  = a + {3'b000, b};
    assign res.ge   = (res.sum >= n_ext);
    assign res.diff = res.sum - n_ext;

endmodule

/* hw/rtl/scope_trigger_capture_controller.sv */
// ----------------------------------------------------------------------------
// scope_trigger_capture_controller
// Trigger state machine and ring index control for a sampling scope.
//
//   channel   direction  handshake             payload
//   event     in         evt_valid / evt_stall mode, dma_remaining
//   result    out        res_valid / res_stall trig_state ... running
//   config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Most events run the execute step, then the finish step loads the result
// register; the next event is accepted once the sequencer is idle again. A buffer
// end first subtracts the ring count in the modulo loop of the shared wrap unit,
// then runs the write advance, DMA and timeout steps (only timeout if refused).
// Reset is asynchronous; the trigger state returns to disabled, indices zero.
// A result held by res_stall does not block acceptance of the next event
// until the sequencer needs the result register again.
// ----------------------------------------------------------------------------
module scope_trigger_capture_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        evt_valid,
    output logic        evt_stall,
    input  logic [2:0]  mode,
    input  logic [12:0] dma_remaining,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [2:0]  trig_state,
    output logic        read_valid,
    output logic [2:0]  read_buffer,
    output logic [2:0]  write_buffer,
    output logic [2:0]  next_dma_buffer,
    output logic        write_blocked,
    output logic [2:0]  trigger_buffer,
    output logic [11:0] trigger_sample,
    output logic        timed_out,
    output logic [1:0]  compare_mode,
    output logic        running,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_WADV = 3'd3;
    localparam logic [2:0] S_DMA  = 3'd4;
    localparam logic [2:0] S_TMO  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    localparam int IW = stc_pkg::IDX_W;
    localparam int AW = stc_pkg::ACC_W;

    stc_pkg::cfg_t      cfg;
    stc_pkg::wrap_res_t wr;

    logic [2:0]                 seq_reg, seq_next;
    logic [2:0]                 mode_reg;
    logic [12:0]                rem_reg;
    logic [2:0]                 st_reg, st_next;
    logic [IW-1:0]              rd_reg, rd_next;
    logic [IW-1:0]              wr_idx_reg, wr_idx_next;
    logic [IW-1:0]              dma_reg, dma_next;
    logic [stc_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       tmo_reg, tmo_next;
    logic [IW-1:0]              tbuf_reg, tbuf_next;
    logic [11:0]                tsmp_reg, tsmp_next;
    logic                       run_reg, run_next;
    logic [AW-1:0]              acc_reg, acc_next;
    logic                       rdv_reg, rdv_next;
    logic                       blk_reg, blk_next;
    logic [AW-1:0]              ua;
    logic [1:0]                 ub;
    logic [IW-1:0]              rd_wrap;
    logic                       waiting;
    logic [13:0]                rem_p1;
    logic [12:0]                smp_full;
    logic                       res_load;

    logic                       res_valid_reg;
    logic [2:0]                 o_state_reg;
    logic                       o_rdv_reg;
    logic [2:0]                 o_rd_reg, o_wr_reg, o_dma_reg, o_tbuf_reg;
    logic                       o_blk_reg, o_tmo_reg, o_run_reg;
    logic [11:0]                o_tsmp_reg;
    logic [1:0]                 o_cmp_reg, cmp_now;

    stc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    stc_wrap_unit u_wrap (
        .a   (ua),
        .b   (ub),
        .n   (cfg.count),
        .res (wr)
    );

    assign cfg_ready = 1'b1;
    assign evt_stall = (seq_reg != S_IDLE);
    assign res_load  = (seq_reg == S_FIN) && (!res_valid_reg || !res_stall);
    assign waiting   = (st_reg == stc_pkg::ST_ENABLED) || (st_reg == stc_pkg::ST_ARMED);
    assign rd_wrap   = wr.ge ? '0 : wr.sum[IW-1:0];
    assign rem_p1    = {1'b0, rem_reg} + 14'd1;
    assign smp_full  = cfg.size - rem_reg - 13'd1;

    always_comb
    begin
        ua = {1'b0, rd_reg};
        ub = 2'd1;
        unique case (seq_reg)
            S_MOD:
            begin
                ua = acc_reg;
                ub = 2'd0;
            end
            S_WADV, S_DMA: ua = {1'b0, wr_idx_reg};
            default:       ;
        endcase
    end

    always_comb
    begin
        seq_next    = seq_reg;
        st_next     = st_reg;
        rd_next     = rd_reg;
        wr_idx_next = wr_idx_reg;
        dma_next    = dma_reg;
        cnt_next    = cnt_reg;
        tmo_next    = tmo_reg;
        tbuf_next   = tbuf_reg;
        tsmp_next   = tsmp_reg;
        run_next    = run_reg;
        acc_next    = acc_reg;
        rdv_next    = rdv_reg;
        blk_next    = blk_reg;

        unique case (seq_reg)
            S_IDLE:
            begin
                if (evt_valid)
                begin
                    rdv_next = 1'b0;
                    blk_next = 1'b0;
                    seq_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                seq_next = S_FIN;
                unique case (mode_reg)
                    stc_pkg::MODE_START:
                    begin
                        wr_idx_next = '0;
                        rd_next     = '0;
                        run_next    = 1'b1;
                        dma_next    = IW'(1);
                    end
                    stc_pkg::MODE_ENABLE:
                    begin
                        if (st_reg == stc_pkg::ST_DISABLED)
                        begin
                            cnt_next = '0;
                            tmo_next = 1'b0;
                            st_next  = stc_pkg::ST_ENABLED;
                            dma_next = IW'(1);
                        end
                    end
                    stc_pkg::MODE_DISABLE:
                    begin
                        if (st_reg == stc_pkg::ST_ENABLED)
                            st_next = stc_pkg::ST_DISABLED;
                    end
                    stc_pkg::MODE_HIT:
                    begin
                        if (st_reg == stc_pkg::ST_ENABLED)
                            st_next = stc_pkg::ST_ARMED;
                        else if (st_reg == stc_pkg::ST_ARMED)
                        begin
                            st_next = stc_pkg::ST_CAPTURING;
                            if (rem_p1 > {1'b0, cfg.size})
                            begin
                                tbuf_next = (wr_idx_reg == '0) ? cfg.count - IW'(1)
                                                               : wr_idx_reg - IW'(1);
                                tsmp_next = 12'(cfg.size - 13'd1);
                            end
                            else
                            begin
                                tbuf_next = wr_idx_reg;
                                tsmp_next = smp_full[11:0];
                            end
                        end
                    end
                    stc_pkg::MODE_BUF_END:
                    begin
                        if (cnt_reg != stc_pkg::CNT_MAX)
                            cnt_next = cnt_reg + 17'd1;
                        if (waiting && (cnt_next >= {14'd0, cfg.pre}))
                            rd_next = rd_wrap;
                        acc_next = {1'b0, wr_idx_reg} + AW'(2);
                        seq_next = S_MOD;
                    end
                    stc_pkg::MODE_FULL:
                    begin
                        if (st_reg == stc_pkg::ST_CAPTURING)
                        begin
                            wr_idx_next = rd_reg;
                            st_next     = stc_pkg::ST_DONE;
                        end
                        run_next = 1'b0;
                    end
                    stc_pkg::MODE_GET_RD:
                    begin
                        if (st_reg == stc_pkg::ST_DISABLED || st_reg == stc_pkg::ST_READING)
                            rdv_next = (rd_reg != wr_idx_reg);
                        else if (st_reg == stc_pkg::ST_DONE)
                        begin
                            rdv_next = 1'b1;
                            st_next  = stc_pkg::ST_READING;
                        end
                    end
                    stc_pkg::MODE_ADV_RD:
                    begin
                        rd_next = rd_wrap;
                        if (rd_wrap == wr_idx_reg && st_reg == stc_pkg::ST_READING)
                            st_next = stc_pkg::ST_DISABLED;
                    end
                    default: ;
                endcase
            end
            S_MOD:
            begin
                if (wr.ge)
                    acc_next = wr.diff;
                else if (acc_reg[IW-1:0] == rd_reg)
                begin
                    blk_next = 1'b1;
                    seq_next = S_TMO;
                end
                else
                    seq_next = S_WADV;
            end
            S_WADV:
            begin
                wr_idx_next = rd_wrap;
                seq_next    = S_DMA;
            end
            S_DMA:
            begin
                dma_next = wr.ge ? wr.diff[IW-1:0] : wr.sum[IW-1:0];
                seq_next = S_TMO;
            end
            S_TMO:
            begin
                if (waiting && cfg.timeout != '0 && cnt_reg > {1'b0, cfg.timeout})
                begin
                    tmo_next  = 1'b1;
                    st_next   = stc_pkg::ST_CAPTURING;
                    tbuf_next = '0;
                    tsmp_next = '0;
                end
                seq_next = S_FIN;
            end
            S_FIN:
            begin
                if (res_load)
                    seq_next = S_IDLE;
            end
            default: seq_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg    <= S_IDLE;
            st_reg     <= stc_pkg::ST_DISABLED;
            rd_reg     <= '0;
            wr_idx_reg <= '0;
            dma_reg    <= '0;
            cnt_reg    <= '0;
            tmo_reg    <= 1'b0;
            tbuf_reg   <= '0;
            tsmp_reg   <= '0;
            run_reg    <= 1'b0;
            rdv_reg    <= 1'b0;
            blk_reg    <= 1'b0;
        end
        else
        begin
            seq_reg    <= seq_next;
            st_reg     <= st_next;
            rd_reg     <= rd_next;
            wr_idx_reg <= wr_idx_next;
            dma_reg    <= dma_next;
            cnt_reg    <= cnt_next;
            tmo_reg    <= tmo_next;
            tbuf_reg   <= tbuf_next;
            tsmp_reg   <= tsmp_next;
            run_reg    <= run_next;
            rdv_reg    <= rdv_next;
            blk_reg    <= blk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (seq_reg == S_IDLE && evt_valid)
        begin
            mode_reg <= mode;
            rem_reg  <= dma_remaining;
        end
    end

    always_comb
    begin
        cmp_now = stc_pkg::CMP_OFF;
        if (st_reg == stc_pkg::ST_ENABLED)
            cmp_now = cfg.rising ? stc_pkg::CMP_BELOW : stc_pkg::CMP_ABOVE;
        else if (st_reg == stc_pkg::ST_ARMED)
            cmp_now = cfg.rising ? stc_pkg::CMP_ABOVE : stc_pkg::CMP_BELOW;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_load)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            o_state_reg <= st_reg;
            o_rdv_reg   <= rdv_reg;
            o_rd_reg    <= rd_reg[2:0];
            o_wr_reg    <= wr_idx_reg[2:0];
            o_dma_reg   <= dma_reg[2:0];
            o_blk_reg   <= blk_reg;
            o_tbuf_reg  <= tbuf_reg[2:0];
            o_tsmp_reg  <= tsmp_reg;
            o_tmo_reg   <= tmo_reg;
            o_cmp_reg   <= cmp_now;
            o_run_reg   <= run_reg;
        end
    end

    assign res_valid       = res_valid_reg;
    assign trig_state      = o_state_reg;
    assign read_valid      = o_rdv_reg;
    assign read_buffer     = o_rd_reg;
    assign write_buffer    = o_wr_reg;
    assign next_dma_buffer = o_dma_reg;
    assign write_blocked   = o_blk_reg;
    assign trigger_buffer  = o_tbuf_reg;
    assign trigger_sample  = o_tsmp_reg;
    assign timed_out       = o_tmo_reg;
    assign compare_mode    = o_cmp_reg;
    assign running         = o_run_reg;

`ifndef ASSERT_OFF
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (trig_state != 3'd6 && trig_state != 3'd7))
        else $error("trigger state out of range");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(read_valid && write_blocked))
        else $error("read valid and write blocked in one result");

    a_cmp_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (compare_mode != 2'd3))
        else $error("undefined compare mode");

    a_mod_exit: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == S_MOD |=> (seq_reg == S_MOD || seq_reg == S_WADV || seq_reg == S_TMO))
        else $error("modulo loop left to a wrong step");
`endif

endmodule
